/* src/cpa_pkg.sv */
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, codes and reset values for the contiguous page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

    // Field widths fixed by the interface.
    localparam int OPCODE_W = 1;
    localparam int COUNT_W  = 9;
    localparam int START_W  = 8;
    localparam int STATUS_W = 2;
    localparam int FIRST_W  = 8;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Default number of page frames held in the tables.
    localparam int DEF_MAX_PAGES = 256;

    // Register reset values.
    localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 9'd256;
    localparam logic [CFG_W-1:0] RESERVED_RST     = 9'd1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED     = 1'b1;

    // Request codes.
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    // Result codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_START = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_RELEASE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/contiguous_page_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous page runs, with a used bit and a run
// length kept for every page frame in two single-port synchronous memories.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Word
//  request   in         i_in_valid / o_in_ready    opcode, page count, run start
//  result    out        o_out_valid / i_out_ready  status, first page
//  config    in         i_cfg_we (no wait)         register index, data
//
//  An allocate scans for its run, reading one used bit a cycle through the
//  used-bit memory port, and then marks it, writing one page a cycle through
//  the same port; one that finds no room reports when the scan runs out. A
//  free reads the run length kept at its start and then releases the run
//  page by page through the used-bit port. A zero count or a bad run start
//  goes straight to its result. After reset a clearing pass zeroes both
//  memories while o_in_ready stays low; configuration writes are taken
//  throughout. A finished result sits in the output register, and a
//  following request is taken at once but holds its own result until the
//  register has been emptied.
//
`default_nettype none

module contiguous_page_allocator #(
    parameter int MAX_PAGES = cpa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write port.
    input  wire logic                         i_cfg_we,
    input  wire logic [cpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cpa_pkg::CFG_W-1:0]    i_cfg_data,
    // Request channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [cpa_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [cpa_pkg::COUNT_W-1:0]  i_page_count,
    input  wire logic [cpa_pkg::START_W-1:0]  i_run_start,
    // Result channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [cpa_pkg::STATUS_W-1:0]      o_status,
    output logic [cpa_pkg::FIRST_W-1:0]       o_first_page
);

    import cpa_pkg::*;

    // Page address width, and a wider width for page numbers and limits, so
    // that the sum of a run start and a run length never wraps.
    localparam int AW = $clog2(MAX_PAGES);
    localparam int LW = (AW + 1 > 10) ? AW + 1 : 10;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_pages_in_use;
    logic [CFG_W-1:0]      r_reserved;

    logic [LW-1:0]         r_ptr, n_ptr;        // scan, mark, release and clear pointer
    logic [LW-1:0]         r_head, n_head;      // first page of the run in hand
    logic [COUNT_W-1:0]    r_len, n_len;        // free pages seen in a row
    logic [COUNT_W-1:0]    r_count, n_count;    // run length asked for or recorded
    logic                  r_pend, n_pend;      // a used-bit read is in flight
    logic [LW-1:0]         r_paddr, n_paddr;    // page of the read in flight
    logic [OPCODE_W-1:0]   r_op, n_op;
    logic [STATUS_W-1:0]   r_status, n_status;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [FIRST_W-1:0]    r_out_first;

    // Memories and their registered read data.
    logic                  r_used_mem [MAX_PAGES];
    logic [COUNT_W-1:0]    r_len_mem  [MAX_PAGES];
    logic                  r_used_q;
    logic [COUNT_W-1:0]    r_len_q;

    // Memory port controls.
    logic                  used_we, used_re, used_wdata;
    logic [AW-1:0]         used_waddr, used_raddr;
    logic                  len_we, len_re;
    logic [AW-1:0]         len_addr;
    logic [COUNT_W-1:0]    len_wdata;

    // ------------------------------------------------------------------
    // Derived limits and decisions
    // ------------------------------------------------------------------
    logic [LW-1:0]         pin_ext, res_ext, limit, first_usable, start_ext, run_end;
    logic                  in_take, out_take, out_load;
    logic                  scan_issue, scan_found, scan_exhausted;
    logic [COUNT_W:0]      scan_len_inc;
    logic                  free_bad;
    logic                  mark_last, release_last, clear_last;

    // Pages at or above pages_in_use are absent, and the table never grows
    // past its own depth. The reserved region is clipped to that limit.
    assign pin_ext      = LW'(r_pages_in_use);
    assign res_ext      = LW'(r_reserved);
    assign limit        = (pin_ext > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : pin_ext;
    assign first_usable = (res_ext > limit) ? limit : res_ext;
    assign start_ext    = LW'(i_run_start);
    assign run_end      = r_head + LW'(r_count) - LW'(1);

    assign in_take  = i_in_valid && o_in_ready;
    assign out_take = r_out_valid && i_out_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // The scan keeps one read in flight: the used bit of page r_paddr arrives
    // while the read of the next page is issued.
    assign scan_issue     = (r_ptr < limit);
    assign scan_len_inc   = {1'b0, r_len} + (COUNT_W + 1)'(1);
    assign scan_found     = r_pend && !r_used_q && (scan_len_inc == {1'b0, r_count});
    assign scan_exhausted = !r_pend && !scan_issue;

    // A run start outside the unreserved managed pages is never a run start.
    assign free_bad = (start_ext < res_ext) || (start_ext >= limit) ||
                      (start_ext >= LW'(MAX_PAGES));

    assign mark_last    = (r_ptr == run_end);
    assign release_last = (r_ptr == run_end) || (r_ptr == LW'(MAX_PAGES - 1));
    assign clear_last   = (r_ptr == LW'(MAX_PAGES - 1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    if (i_opcode == OP_ALLOC) begin
                        n_state = (i_page_count == '0) ? S_DONE : S_SCAN;
                    end else begin
                        n_state = free_bad ? S_DONE : S_FREE_RD;
                    end
                end
            end
            S_SCAN: begin
                if (scan_found) begin
                    n_state = S_MARK;
                end else if (scan_exhausted) begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                if (mark_last) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                n_state = (r_len_q == '0) ? S_DONE : S_RELEASE;
            end
            S_RELEASE: begin
                if (release_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: memory controls and working registers
    // ------------------------------------------------------------------
    always_comb begin
        n_ptr      = r_ptr;
        n_head     = r_head;
        n_len      = r_len;
        n_count    = r_count;
        n_pend     = 1'b0;
        n_paddr    = r_paddr;
        n_op       = r_op;
        n_status   = r_status;
        used_we    = 1'b0;
        used_re    = 1'b0;
        used_wdata = 1'b0;
        used_waddr = r_ptr[AW-1:0];
        used_raddr = r_ptr[AW-1:0];
        len_we     = 1'b0;
        len_re     = 1'b0;
        len_addr   = r_head[AW-1:0];
        len_wdata  = '0;
        o_in_ready = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // Both tables are zeroed one page a cycle.
                used_we  = 1'b1;
                len_we   = 1'b1;
                len_addr = r_ptr[AW-1:0];
                n_ptr    = r_ptr + LW'(1);
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_take) begin
                    n_op    = i_opcode;
                    n_count = i_page_count;
                    n_len   = '0;
                    n_ptr   = first_usable;
                    n_head  = start_ext;
                    n_status = ST_DONE;
                    if (i_opcode == OP_ALLOC) begin
                        if (i_page_count == '0) begin
                            n_status = ST_ZERO;
                        end
                    end else if (free_bad) begin
                        n_status = ST_NOT_START;
                    end
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    used_re = 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = r_ptr;
                    n_ptr   = r_ptr + LW'(1);
                end
                if (r_pend) begin
                    if (r_used_q) begin
                        n_len = '0;
                    end else begin
                        if (r_len == '0) begin
                            n_head = r_paddr;
                        end
                        n_len = scan_len_inc[COUNT_W-1:0];
                    end
                end
                if (scan_found) begin
                    // Marking starts at the head of the run just found.
                    n_ptr  = (r_len == '0) ? r_paddr : r_head;
                    n_pend = 1'b0;
                end else if (scan_exhausted) begin
                    n_status = ST_NO_ROOM;
                end
            end
            S_MARK: begin
                used_we    = 1'b1;
                used_wdata = 1'b1;
                // The run length is recorded at the head on the first pass.
                if (r_ptr == r_head) begin
                    len_we    = 1'b1;
                    len_wdata = r_count;
                end
                n_ptr = r_ptr + LW'(1);
            end
            S_FREE_RD: begin
                len_re = 1'b1;
            end
            S_FREE_CHK: begin
                n_count = r_len_q;
                n_ptr   = r_head;
                if (r_len_q == '0) begin
                    n_status = ST_NOT_START;
                end
            end
            S_RELEASE: begin
                used_we = 1'b1;
                if (r_ptr == r_head) begin
                    len_we = 1'b1;
                end
                n_ptr = r_ptr + LW'(1);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_pages_in_use <= PAGES_IN_USE_RST;
            r_reserved     <= RESERVED_RST;
            r_ptr          <= '0;
            r_head         <= '0;
            r_len          <= '0;
            r_count        <= '0;
            r_pend         <= 1'b0;
            r_paddr        <= '0;
            r_op           <= OP_ALLOC;
            r_status       <= ST_DONE;
            r_out_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_head   <= n_head;
            r_len    <= n_len;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_paddr  <= n_paddr;
            r_op     <= n_op;
            r_status <= n_status;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAGES_IN_USE: r_pages_in_use <= i_cfg_data;
                    CFG_RESERVED:     r_reserved     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word. The first page is only reported for a successful allocate.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_first  <= (r_status == ST_DONE && r_op == OP_ALLOC) ?
                            r_head[FIRST_W-1:0] : '0;
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_waddr] <= used_wdata;
        end
        if (used_re) begin
            r_used_q <= r_used_mem[used_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[len_addr] <= len_wdata;
        end
        if (len_re) begin
            r_len_q <= r_len_mem[len_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_first_page = r_out_first;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // The used-bit memory is never read and written in the same cycle.
    a_used_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(used_we && used_re))
        else $error("used-bit memory read and written together");

    // A run being marked lies wholly inside the managed pages.
    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (run_end < limit && r_ptr <= run_end))
        else $error("marked run leaves the managed pages");

    // Once a request is taken, no other is taken until it has finished.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> !o_in_ready)
        else $error("request taken while another is in hand");

    // A failed request never reports a page.
    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DONE) |-> (o_first_page == '0))
        else $error("failed request reports a page");
`endif

endmodule

`default_nettype wire

/* tb/cpa_checker.sv */
// ----------------------------------------------------------------------------
// cpa_checker
// Watches the request, result and register ports of the page allocator. It
// keeps its own page tables and register copies, works out the reply owed
// for every request word taken, and compares each reply word taken against
// the oldest one owed.
// ----------------------------------------------------------------------------
module cpa_checker #(
    parameter int MAX_PAGES = cpa_pkg::DEF_MAX_PAGES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cpa_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [cpa_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [cpa_pkg::COUNT_W-1:0]    i_page_count,
    input  wire logic [cpa_pkg::START_W-1:0]    i_run_start,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [cpa_pkg::STATUS_W-1:0]   i_status,
    input  wire logic [cpa_pkg::FIRST_W-1:0]    i_first_page,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import cpa_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIRST_W-1:0]  first_page;
    } t_page_reply;

    logic               page_used  [MAX_PAGES];
    logic [COUNT_W-1:0] run_length [MAX_PAGES];
    logic [CFG_W-1:0]   pages_reg;
    logic [CFG_W-1:0]   reserved_reg;
    t_page_reply        replies_owed [$];
    int                 fails = 0;
    int                 checked = 0;

    function automatic int usable_limit();
        return (int'(pages_reg) > MAX_PAGES) ? MAX_PAGES : int'(pages_reg);
    endfunction

    // First fit from the lowest unreserved page.
    function automatic t_page_reply take_run(input logic [COUNT_W-1:0] count);
        t_page_reply reply;
        int limit, p, head, len;
        bit found;
        reply.status = ST_DONE;
        reply.first_page = '0;
        limit = usable_limit();
        head = 0;
        len = 0;
        found = 1'b0;
        if (count == '0) begin
            reply.status = ST_ZERO;
            return reply;
        end
        p = (int'(reserved_reg) > limit) ? limit : int'(reserved_reg);
        while (p < limit && !found) begin
            if (page_used[p]) begin
                len = 0;
            end else begin
                if (len == 0) head = p;
                len++;
                if (len == int'(count)) found = 1'b1;
            end
            p++;
        end
        if (!found) begin
            reply.status = ST_NO_ROOM;
            return reply;
        end
        for (int i = 0; i < int'(count); i++) page_used[head + i] = 1'b1;
        run_length[head] = count;
        reply.first_page = head[FIRST_W-1:0];
        return reply;
    endfunction

    function automatic t_page_reply release_run(input logic [START_W-1:0] start);
        t_page_reply reply;
        int len;
        reply.status = ST_NOT_START;
        reply.first_page = '0;
        if (start < reserved_reg || int'(start) >= usable_limit() ||
            int'(start) >= MAX_PAGES || run_length[start] == '0) begin
            return reply;
        end
        len = int'(run_length[start]);
        for (int i = 0; i < len && int'(start) + i < MAX_PAGES; i++) begin
            page_used[int'(start) + i] = 1'b0;
        end
        run_length[start] = '0;
        reply.status = ST_DONE;
        return reply;
    endfunction

    task automatic flag_mismatch(input string what, input int seen, input int owed);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d",
                 $time, what, seen, owed);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_page_reply seen;
        t_page_reply owed;
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PAGES; p++) begin
                page_used[p] = 1'b0;
                run_length[p] = '0;
            end
            pages_reg = PAGES_IN_USE_RST;
            reserved_reg = RESERVED_RST;
            replies_owed.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAGES_IN_USE: pages_reg = i_cfg_data;
                    CFG_RESERVED:     reserved_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // A reply leaving at this edge belongs to an earlier request.
            if (i_out_valid && i_out_ready) begin
                seen.status = i_status;
                seen.first_page = i_first_page;
                if (replies_owed.size() == 0) begin
                    flag_mismatch("unrequested reply word, status", int'(seen.status), -1);
                end else begin
                    owed = replies_owed.pop_front();
                    if (seen.status != owed.status) begin
                        flag_mismatch("status", int'(seen.status), int'(owed.status));
                    end
                    if (seen.first_page != owed.first_page) begin
                        flag_mismatch("first page", int'(seen.first_page),
                                      int'(owed.first_page));
                    end
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_ALLOC) begin
                    replies_owed.push_back(take_run(i_page_count));
                end else begin
                    replies_owed.push_back(release_run(i_run_start));
                end
            end
        end
        o_pending = replies_owed.size();
        o_fail_count = fails;
        o_checked = checked;
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the contiguous page allocator. A short directed
// run covers zero counts, oversized requests, runs at both ends of the page
// range and frees of pages that start no run; then random phases, each under
// its own register setting, mix allocations with frees of live runs and junk.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpa_pkg::*;

    localparam int MAX_PAGES     = DEF_MAX_PAGES;
    localparam int PHASES        = 16;
    localparam int PHASE_WORDS   = 100;
    localparam int IDLE_PCT      = 34;
    localparam int HOLD_CYCLES   = 400;
    // The slowest request scans every page and then marks every page.
    localparam int DRAIN_CYCLES  = 2 * MAX_PAGES + 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 4_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [COUNT_W-1:0]   page_count;
    logic [START_W-1:0]   run_start;
    logic                 out_valid;
    logic                 out_ready;
    logic [STATUS_W-1:0]  status;
    logic [FIRST_W-1:0]   first_page;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping. The register copies let the free generator tell
    // a run it can release from one that the current setting has stranded.
    int                 cur_pages = int'(PAGES_IN_USE_RST);
    int                 cur_reserved = int'(RESERVED_RST);
    int                 send_idle_pct = IDLE_PCT;
    int                 recv_idle_pct = IDLE_PCT;
    int                 hold_left = 0;
    int                 words_sent = 0;
    int                 settings_used = 1;
    int                 cycles = 0;
    int                 status_tally [4] = '{default: 0};
    logic [OPCODE_W-1:0] issued_ops [$];
    logic [START_W-1:0]  live_runs [$];

    contiguous_page_allocator #(
        .MAX_PAGES(MAX_PAGES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_opcode    (opcode),
        .i_page_count(page_count),
        .i_run_start (run_start),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_status    (status),
        .o_first_page(first_page)
    );

    cpa_checker #(
        .MAX_PAGES(MAX_PAGES)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_opcode    (opcode),
        .i_page_count(page_count),
        .i_run_start (run_start),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_status    (status),
        .i_first_page(first_page),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: the run is abandoned if it outlasts a generous multiple of
    // the slowest legal run.
    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Run abandoned after %0d cycles with %0d replies outstanding.", cycles,
                 pending);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver. It stalls at random, and when asked it holds off for a long
    // stretch which it counts down itself, so that the allocator's output
    // register fills and the request channel backs up behind it.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Pair every reply with the request that caused it, so that the start
    // pages of granted runs can be fed back as well-formed frees.
    always @(posedge clk) begin
        logic [OPCODE_W-1:0] op_seen;
        if (rst_n) begin
            if (out_valid && out_ready && issued_ops.size() != 0) begin
                op_seen = issued_ops.pop_front();
                status_tally[status]++;
                if (op_seen == OP_ALLOC && status == ST_DONE) live_runs.push_back(first_page);
            end
            if (in_valid && in_ready) issued_ops.push_back(opcode);
        end
    end

    // Offers one request word. Valid is left high after acceptance: the next
    // word either keeps it high or the idle decision lowers it, so the flag
    // sees only one assignment per falling edge.
    task automatic offer_word(input logic [OPCODE_W-1:0] op,
                              input logic [COUNT_W-1:0] count,
                              input logic [START_W-1:0] start);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        page_count <= count;
        run_start  <= start;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    // Lowers valid and waits until every reply has been taken.
    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Registers are only touched with the allocator idle: every request owes
    // exactly one reply, so once none is outstanding the engine has finished
    // and is back in idle.
    task automatic set_registers(input int pages, input int reserved);
        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_register(CFG_PAGES_IN_USE, pages[CFG_W-1:0]);
        write_register(CFG_RESERVED, reserved[CFG_W-1:0]);
        cur_pages = pages;
        cur_reserved = reserved;
        settings_used++;
    endtask

    // One random request. Most frees name a live run; the rest are junk
    // starts, which exercise the not-a-run-start path. Allocations are mostly
    // small, with zero counts, counts up to the page range and counts well
    // past it mixed in.
    task automatic random_request();
        int roll, limit, pick;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        limit = (cur_pages > MAX_PAGES) ? MAX_PAGES : cur_pages;
        roll = $urandom_range(0, 99);
        if (roll < 48) begin
            if (live_runs.size() != 0 && $urandom_range(0, 99) < 80) begin
                pick = $urandom_range(0, live_runs.size() - 1);
                start = live_runs[pick];
                // A run stranded by the current setting stays on the list.
                if (start >= cur_reserved && start < limit) live_runs.delete(pick);
            end else begin
                start = START_W'($urandom_range(0, 255));
            end
            offer_word(OP_FREE, COUNT_W'($urandom_range(0, 511)), start);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 6) count = '0;
            else if (roll < 12) count = COUNT_W'($urandom_range(0, 511));
            else if (roll < 20) count = COUNT_W'($urandom_range(1, (limit > 0) ? limit : 1));
            else count = COUNT_W'($urandom_range(1, $urandom_range(1, 8)));
            offer_word(OP_ALLOC, count, START_W'($urandom_range(0, 255)));
        end
    endtask

    // Random setting: mostly small tables with a little reserved, sometimes
    // the full table, sometimes anything the 9-bit registers can hold.
    task automatic pick_setting(output int pages, output int reserved);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) pages = MAX_PAGES;
        else if (roll < 30) pages = $urandom_range(0, 511);
        else pages = $urandom_range(4, 64);
        roll = $urandom_range(0, 99);
        if (roll < 60) reserved = $urandom_range(0, 3);
        else if (roll < 85) reserved = $urandom_range(0, (pages > 511) ? 511 : pages);
        else reserved = $urandom_range(0, 511);
    endtask

    initial begin
        int pages, reserved;
        logic [START_W-1:0] start;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PAGES_IN_USE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        opcode     = OP_ALLOC;
        page_count = '0;
        run_start  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset setting: 256 pages, page 0 reserved.
        // Requests wait on the handshake through the clearing pass.
        offer_word(OP_ALLOC, 9'd0, 8'd0);       // zero count
        offer_word(OP_ALLOC, 9'd511, 8'd255);   // far beyond the page range
        offer_word(OP_ALLOC, 9'd256, 8'd0);     // one more than the free pages
        offer_word(OP_ALLOC, 9'd255, 8'd0);     // every free page, from page 1
        offer_word(OP_ALLOC, 9'd1, 8'd0);       // nothing left
        offer_word(OP_FREE, 9'd0, 8'd0);        // reserved page
        offer_word(OP_FREE, 9'd511, 8'd2);      // inside a run, not its start
        offer_word(OP_FREE, 9'd0, 8'd1);
        offer_word(OP_ALLOC, 9'd1, 8'd0);
        offer_word(OP_ALLOC, 9'd254, 8'd0);     // run ending on the top page
        offer_word(OP_FREE, 9'd0, 8'd255);      // top page, no run starts there
        offer_word(OP_FREE, 9'd0, 8'd2);
        offer_word(OP_ALLOC, 9'd253, 8'd0);
        offer_word(OP_ALLOC, 9'd1, 8'd0);       // single page run on the top page
        offer_word(OP_FREE, 9'd0, 8'd255);
        offer_word(OP_FREE, 9'd0, 8'd2);
        offer_word(OP_FREE, 9'd0, 8'd1);

        // Small table with nothing reserved: a run can start on page 0.
        set_registers(16, 0);
        offer_word(OP_ALLOC, 9'd16, 8'd0);
        offer_word(OP_FREE, 9'd0, 8'd0);
        offer_word(OP_ALLOC, 9'd17, 8'd0);
        offer_word(OP_ALLOC, 9'd4, 8'd0);

        // Reserved region above the managed limit: the live run at page 0 is
        // stranded and nothing can be allocated.
        set_registers(511, 300);
        offer_word(OP_FREE, 9'd0, 8'd0);
        offer_word(OP_ALLOC, 9'd1, 8'd0);
        set_registers(MAX_PAGES, 0);
        offer_word(OP_FREE, 9'd0, 8'd0);

        // Random phases, each under its own setting. The first few pin the
        // extremes; the rest favour small tables so that scans stay short.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin pages = 511; reserved = 0; end
                1: begin pages = 1; reserved = 0; end
                2: begin pages = 32; reserved = 2; end
                3: begin pages = 0; reserved = 0; end
                4: begin pages = 256; reserved = 256; end
                5: begin pages = 64; reserved = 1; end
                6: begin pages = 2; reserved = 511; end
                7: begin pages = 256; reserved = 0; end
                default: begin
                    pick_setting(pages, reserved);
                end
            endcase
            set_registers(pages, reserved);

            // One phase runs flat out on both sides.
            send_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            recv_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            // One phase opens with a long receiver hold-off while requests
            // keep coming.
            if (phase == 5) hold_left = HOLD_CYCLES;

            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Midway through one phase the sender stops until every
                // reply is home, then carries on.
                if (phase == 7 && n == PHASE_WORDS / 2) drain_replies();
                random_request();
            end

            // Now and then release every live run under a wide setting, so
            // that the tables do not silt up with stranded runs.
            if (phase % 4 == 3) begin
                set_registers(MAX_PAGES, 0);
                while (live_runs.size() != 0) begin
                    start = live_runs.pop_front();
                    offer_word(OP_FREE, COUNT_W'($urandom_range(0, 511)), start);
                end
            end
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d request words over %0d register settings;",
                 words_sent, settings_used);
        $display("replies: %0d done, %0d no room, %0d not a run start, %0d zero count;",
                 status_tally[ST_DONE], status_tally[ST_NO_ROOM],
                 status_tally[ST_NOT_START], status_tally[ST_ZERO]);
        $display("%0d replies compared, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
